@@ sv/cpw_pkg.sv @@
//------------------------------------------------------------------------------
// cpw_pkg
// Shared constants, codes, types and helpers of the CIGAR pileup window.
//------------------------------------------------------------------------------
package cpw_pkg;

    // geometry
    localparam int WINDOW = 1024;  // reference positions in the ring, 32..65536
    localparam int DEPTH  = 64;    // entries per position list, 1..64

    localparam int WIN_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ST_AW  = $clog2(WINDOW * DEPTH);

    // field widths
    localparam int FUNC_W = 2;
    localparam int OP_W   = 4;
    localparam int LEN_W  = 28;
    localparam int CODE_W = 4;
    localparam int QUAL_W = 8;
    localparam int NT_W   = 3;
    localparam int OFS_W  = 32;
    localparam int ENT_W  = NT_W + QUAL_W;

    // item functions
    localparam logic [FUNC_W-1:0] FN_START = 2'd0;
    localparam logic [FUNC_W-1:0] FN_OP    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_BASE  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_MOVE  = 2'd3;

    // BAM cigar op codes
    localparam logic [OP_W-1:0] OP_M = 4'd0;
    localparam logic [OP_W-1:0] OP_I = 4'd1;
    localparam logic [OP_W-1:0] OP_D = 4'd2;
    localparam logic [OP_W-1:0] OP_N = 4'd3;
    localparam logic [OP_W-1:0] OP_S = 4'd4;

    // BAM base nibbles
    localparam logic [CODE_W-1:0] BASE_A = 4'd1;
    localparam logic [CODE_W-1:0] BASE_C = 4'd2;
    localparam logic [CODE_W-1:0] BASE_G = 4'd4;
    localparam logic [CODE_W-1:0] BASE_T = 4'd8;
    localparam logic [CODE_W-1:0] BASE_N = 4'd15;

    // result kinds
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SKIP    = 3'd1,
        ST_OUT_WIN = 3'd2,
        ST_FULL    = 3'd3,
        ST_BAD_OP  = 3'd4,
        ST_UNEXP   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT,
        S_DRAIN,
        S_ACK
    } t_state;

    typedef struct packed {
        logic              kind;
        t_status           status;
        logic [NT_W-1:0]   nucleotide;
        logic [QUAL_W-1:0] entry_quality;
        logic              last;
    } t_out_beat;

    function automatic logic [NT_W-1:0] nt_of(input logic [CODE_W-1:0] code);
        logic [NT_W-1:0] nt;
        case (code)
            BASE_A:  nt = 3'd1;
            BASE_C:  nt = 3'd2;
            BASE_G:  nt = 3'd3;
            BASE_T:  nt = 3'd4;
            default: nt = 3'd0;
        endcase
        return nt;
    endfunction

endpackage

@@ sv/cpw_if.sv @@
//------------------------------------------------------------------------------
// cpw_if
// Valid/ready channels of the pileup window: item input and result output.
//------------------------------------------------------------------------------
interface cpw_in_if;
    logic                        valid;
    logic                        ready;
    logic [cpw_pkg::FUNC_W-1:0]  func;
    logic [cpw_pkg::QUAL_W-1:0]  map_quality;
    logic [cpw_pkg::OP_W-1:0]    cigar_op;
    logic [cpw_pkg::LEN_W-1:0]   op_length;
    logic [cpw_pkg::CODE_W-1:0]  base_code;
    logic [cpw_pkg::QUAL_W-1:0]  base_quality;

    modport source (
        output valid, func, map_quality, cigar_op, op_length, base_code, base_quality,
        input  ready
    );
    modport sink (
        input  valid, func, map_quality, cigar_op, op_length, base_code, base_quality,
        output ready
    );
endinterface

interface cpw_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [2:0]                  status;
    logic [cpw_pkg::NT_W-1:0]    nucleotide;
    logic [cpw_pkg::QUAL_W-1:0]  entry_quality;
    logic                        last;

    modport source (
        output valid, kind, status, nucleotide, entry_quality, last,
        input  ready
    );
    modport sink (
        input  valid, kind, status, nucleotide, entry_quality, last,
        output ready
    );
endinterface

@@ sv/cpw_ram.sv @@
//------------------------------------------------------------------------------
// cpw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
//------------------------------------------------------------------------------
module cpw_ram #(
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/cpw_out_buf.sv @@
//------------------------------------------------------------------------------
// cpw_out_buf
// Two-beat result buffer; decouples the sequencer from output back-pressure.
//------------------------------------------------------------------------------
module cpw_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cpw_pkg::t_out_beat i_beat,
    output logic               o_full,
    cpw_out_if.source          o_out
);

    cpw_pkg::t_out_beat r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    logic               pop;
    cpw_pkg::t_out_beat head;

    assign pop  = o_out.valid && o_out.ready;
    assign head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_beat;
        end
    end

    assign o_full              = (r_cnt == 2'd2);
    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.kind          = head.kind;
    assign o_out.status        = head.status;
    assign o_out.nucleotide    = head.nucleotide;
    assign o_out.entry_quality = head.entry_quality;
    assign o_out.last          = head.last;

endmodule

@@ sv/cigar_pileup_window.sv @@
//------------------------------------------------------------------------------
// cigar_pileup_window
// Pileup ring over reference positions, list counts and entries held in RAM.
//------------------------------------------------------------------------------
// Items are taken one at a time. Start, cigar op and dropped-base acks are
//   pushed in the accept cycle and registered by the result buffer; a stored
//   base acks from S_CNT (S_ACK if the buffer is full); a move clears the head
//   count in S_CNT, then drains its entries in S_DRAIN, stalling on a full buffer.
// Reset: synchronous, active low; then a clearing pass writes every list count
//   to zero, during which no item is accepted.
//------------------------------------------------------------------------------
module cigar_pileup_window (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cpw_in_if.sink    i_in,
    cpw_out_if.source o_out
);

    localparam int WIN_W  = cpw_pkg::WIN_W;
    localparam int CNT_W  = cpw_pkg::CNT_W;
    localparam int ST_AW  = cpw_pkg::ST_AW;
    localparam int OFS_W  = cpw_pkg::OFS_W;
    localparam int LEN_W  = cpw_pkg::LEN_W;
    localparam int QUAL_W = cpw_pkg::QUAL_W;
    localparam int NT_W   = cpw_pkg::NT_W;
    localparam int ENT_W  = cpw_pkg::ENT_W;

    // sequencer and read state
    cpw_pkg::t_state    r_state, n_state;
    logic [WIN_W-1:0]   r_head, n_head;      // ring head position
    logic [OFS_W-1:0]   r_ofs, n_ofs;        // reference offset from head
    logic [LEN_W-1:0]   r_rem, n_rem;        // bases left in current op
    logic               r_keep, n_keep;      // current op stores bases
    logic [QUAL_W-1:0]  r_mapq, n_mapq;      // mapping quality of the read
    logic [WIN_W-1:0]   r_clr, n_clr;        // clearing pass address

    // per-item working registers
    logic [WIN_W-1:0]   r_pos, n_pos;
    logic               r_is_move, n_is_move;
    logic [NT_W-1:0]    r_nt, n_nt;
    logic [QUAL_W-1:0]  r_q, n_q;
    cpw_pkg::t_status   r_status, n_status;
    logic [CNT_W-1:0]   r_k, n_k;            // drain index
    logic [CNT_W-1:0]   r_n, n_n;            // drain length

    // memory ports
    logic               cnt_we, cnt_re;
    logic [WIN_W-1:0]   cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
    logic               st_we, st_re;
    logic [ST_AW-1:0]   st_waddr, st_raddr;
    logic [ENT_W-1:0]   st_wdata, st_rdata;

    // result buffer
    logic               buf_push, buf_full;
    cpw_pkg::t_out_beat beat;

    // datapath helpers
    logic [WIN_W:0]     pos_sum;
    logic [WIN_W-1:0]   pos_mod;
    logic [OFS_W:0]     ofs_len_sum;
    logic [OFS_W-1:0]   ofs_len_sat, ofs_inc_sat, ofs_dec_sat;
    logic [WIN_W-1:0]   head_next;
    logic [QUAL_W-1:0]  q_min;
    logic [ST_AW-1:0]   st_base;
    logic [CNT_W-1:0]   k_next;
    logic               drain_last;
    logic               ofs_in_win;
    logic               take;
    logic               mem_path;

    // head + offset wraps at most once: offset is below WINDOW on this path
    assign pos_sum = (WIN_W+1)'(r_head) + (WIN_W+1)'(r_ofs[WIN_W-1:0]);
    assign pos_mod = (pos_sum >= (WIN_W+1)'(cpw_pkg::WINDOW))
                   ? WIN_W'(pos_sum - (WIN_W+1)'(cpw_pkg::WINDOW))
                   : WIN_W'(pos_sum);

    // saturating offset arithmetic
    assign ofs_len_sum = (OFS_W+1)'(r_ofs) + (OFS_W+1)'(i_in.op_length);
    assign ofs_len_sat = ofs_len_sum[OFS_W] ? '1 : ofs_len_sum[OFS_W-1:0];
    assign ofs_inc_sat = (r_ofs == '1) ? r_ofs : r_ofs + OFS_W'(1);
    assign ofs_dec_sat = (r_ofs == '0) ? r_ofs : r_ofs - OFS_W'(1);
    assign ofs_in_win  = (r_ofs < OFS_W'(cpw_pkg::WINDOW));

    assign head_next = (r_head == WIN_W'(cpw_pkg::WINDOW - 1)) ? '0 : r_head + WIN_W'(1);
    assign q_min     = (i_in.base_quality < r_mapq) ? i_in.base_quality : r_mapq;

    // list of position p starts at p * DEPTH in the entry store
    assign st_base    = ST_AW'(ST_AW'(r_pos) * ST_AW'(cpw_pkg::DEPTH));
    assign k_next     = r_k + CNT_W'(1);
    assign drain_last = (k_next == r_n);

    assign take = (r_state == cpw_pkg::S_IDLE) && i_in.valid && !buf_full;

    // items that need a list count read
    assign mem_path = take &&
        ((i_in.func == cpw_pkg::FN_MOVE) ||
         ((i_in.func == cpw_pkg::FN_BASE) && (r_rem != '0) && r_keep &&
          (i_in.base_code != cpw_pkg::BASE_N) && ofs_in_win));

    assign i_in.ready = (r_state == cpw_pkg::S_IDLE) && !buf_full;

    //--------------------------------------------------------------------------
    // next state
    //--------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpw_pkg::S_CLEAR: begin
                if (r_clr == WIN_W'(cpw_pkg::WINDOW - 1)) begin
                    n_state = cpw_pkg::S_IDLE;
                end
            end
            cpw_pkg::S_IDLE: begin
                if (mem_path) begin
                    n_state = cpw_pkg::S_CNT;
                end
            end
            cpw_pkg::S_CNT: begin
                if (r_is_move && (cnt_rdata != '0)) begin
                    n_state = cpw_pkg::S_DRAIN;
                end else if (buf_full) begin
                    n_state = cpw_pkg::S_ACK;
                end else begin
                    n_state = cpw_pkg::S_IDLE;
                end
            end
            cpw_pkg::S_DRAIN: begin
                if (!buf_full && drain_last) begin
                    n_state = cpw_pkg::S_IDLE;
                end
            end
            cpw_pkg::S_ACK: begin
                if (!buf_full) begin
                    n_state = cpw_pkg::S_IDLE;
                end
            end
            default: n_state = cpw_pkg::S_CLEAR;
        endcase
    end

    //--------------------------------------------------------------------------
    // outputs, memory controls and register updates
    //--------------------------------------------------------------------------
    always_comb begin
        n_head    = r_head;
        n_ofs     = r_ofs;
        n_rem     = r_rem;
        n_keep    = r_keep;
        n_mapq    = r_mapq;
        n_clr     = r_clr;
        n_pos     = r_pos;
        n_is_move = r_is_move;
        n_nt      = r_nt;
        n_q       = r_q;
        n_status  = r_status;
        n_k       = r_k;
        n_n       = r_n;

        cnt_we    = 1'b0;
        cnt_waddr = r_pos;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = r_pos;
        st_we     = 1'b0;
        st_waddr  = ST_AW'(st_base + ST_AW'(cnt_rdata));
        st_wdata  = {r_nt, r_q};
        st_re     = 1'b0;
        st_raddr  = st_base;

        buf_push           = 1'b0;
        beat.kind          = cpw_pkg::KIND_ACK;
        beat.status        = cpw_pkg::ST_OK;
        beat.nucleotide    = '0;
        beat.entry_quality = '0;
        beat.last          = 1'b1;

        case (r_state)
            cpw_pkg::S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                n_clr     = r_clr + WIN_W'(1);
            end
            cpw_pkg::S_IDLE: begin
                if (take) begin
                    case (i_in.func)
                        cpw_pkg::FN_START: begin
                            n_mapq   = i_in.map_quality;
                            n_ofs    = '0;
                            n_rem    = '0;
                            n_keep   = 1'b0;
                            buf_push = 1'b1;
                        end
                        cpw_pkg::FN_OP: begin
                            buf_push = 1'b1;
                            case (i_in.cigar_op)
                                cpw_pkg::OP_M: begin
                                    n_rem  = i_in.op_length;
                                    n_keep = 1'b1;
                                end
                                cpw_pkg::OP_I, cpw_pkg::OP_S: begin
                                    n_rem  = i_in.op_length;
                                    n_keep = 1'b0;
                                end
                                cpw_pkg::OP_D, cpw_pkg::OP_N: begin
                                    n_ofs = ofs_len_sat;
                                    n_rem = '0;
                                end
                                default: beat.status = cpw_pkg::ST_BAD_OP;
                            endcase
                        end
                        cpw_pkg::FN_BASE: begin
                            if (r_rem == '0) begin
                                buf_push    = 1'b1;
                                beat.status = cpw_pkg::ST_UNEXP;
                            end else begin
                                n_rem = r_rem - LEN_W'(1);
                                if (r_keep) begin
                                    n_ofs = ofs_inc_sat;
                                end
                                if (!r_keep || (i_in.base_code == cpw_pkg::BASE_N)) begin
                                    buf_push    = 1'b1;
                                    beat.status = cpw_pkg::ST_SKIP;
                                end else if (!ofs_in_win) begin
                                    buf_push    = 1'b1;
                                    beat.status = cpw_pkg::ST_OUT_WIN;
                                end else begin
                                    cnt_re    = 1'b1;
                                    cnt_raddr = pos_mod;
                                    n_pos     = pos_mod;
                                    n_nt      = cpw_pkg::nt_of(i_in.base_code);
                                    n_q       = q_min;
                                    n_is_move = 1'b0;
                                end
                            end
                        end
                        cpw_pkg::FN_MOVE: begin
                            cnt_re    = 1'b1;
                            cnt_raddr = r_head;
                            n_pos     = r_head;
                            n_head    = head_next;
                            n_ofs     = ofs_dec_sat;
                            n_is_move = 1'b1;
                        end
                        default: buf_push = 1'b0;
                    endcase
                end
            end
            cpw_pkg::S_CNT: begin
                if (r_is_move) begin
                    // clear the head list; drain what it held
                    cnt_we = 1'b1;
                    if (cnt_rdata == '0) begin
                        buf_push = !buf_full;
                        n_status = cpw_pkg::ST_OK;
                    end else begin
                        st_re    = 1'b1;
                        st_raddr = st_base;
                        n_k      = '0;
                        n_n      = cnt_rdata;
                    end
                end else begin
                    if (cnt_rdata >= CNT_W'(cpw_pkg::DEPTH)) begin
                        n_status    = cpw_pkg::ST_FULL;
                        beat.status = cpw_pkg::ST_FULL;
                    end else begin
                        st_we     = 1'b1;
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_rdata + CNT_W'(1);
                        n_status  = cpw_pkg::ST_OK;
                    end
                    buf_push = !buf_full;
                end
            end
            cpw_pkg::S_DRAIN: begin
                beat.kind          = cpw_pkg::KIND_ENTRY;
                beat.nucleotide    = st_rdata[ENT_W-1:QUAL_W];
                beat.entry_quality = st_rdata[QUAL_W-1:0];
                beat.last          = drain_last;
                if (!buf_full) begin
                    buf_push = 1'b1;
                    if (!drain_last) begin
                        st_re    = 1'b1;
                        st_raddr = ST_AW'(st_base + ST_AW'(k_next));
                        n_k      = k_next;
                    end
                end
            end
            cpw_pkg::S_ACK: begin
                beat.status = r_status;
                buf_push    = !buf_full;
            end
            default: buf_push = 1'b0;
        endcase
    end

    //--------------------------------------------------------------------------
    // registers
    //--------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpw_pkg::S_CLEAR;
            r_head  <= '0;
            r_ofs   <= '0;
            r_rem   <= '0;
            r_keep  <= 1'b0;
            r_mapq  <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_ofs   <= n_ofs;
            r_rem   <= n_rem;
            r_keep  <= n_keep;
            r_mapq  <= n_mapq;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_is_move <= n_is_move;
        r_nt      <= n_nt;
        r_q       <= n_q;
        r_status  <= n_status;
        r_k       <= n_k;
        r_n       <= n_n;
    end

    //--------------------------------------------------------------------------
    // memories and result buffer
    //--------------------------------------------------------------------------
    cpw_ram #(
        .AW (WIN_W),
        .DW (CNT_W)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    cpw_ram #(
        .AW (ST_AW),
        .DW (ENT_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    cpw_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (buf_push),
        .i_beat  (beat),
        .o_full  (buf_full),
        .o_out   (o_out)
    );

    //--------------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------------
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_push |-> !buf_full)
        else $error("result pushed into a full buffer");

    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpw_pkg::S_DRAIN) |-> (r_k < r_n))
        else $error("drain index beyond list length");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpw_pkg::S_CNT) |-> (cnt_rdata <= CNT_W'(cpw_pkg::DEPTH)))
        else $error("list count above depth");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpw_pkg::S_CLEAR) |-> !i_in.ready)
        else $error("item accepted during clearing pass");

endmodule

@@ tb/sv/cpw_pileup_checker.sv @@
//------------------------------------------------------------------------------
// cpw_pileup_checker
// Watches both channels of the pileup window, predicts every result beat from
// the accepted items and compares the result stream against that prediction.
//------------------------------------------------------------------------------
module cpw_pileup_checker
    import cpw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cpw_in_if    i_in,
    cpw_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    // predicted block state
    logic [WIN_W-1:0]  head_pos;
    logic [OFS_W-1:0]  ref_ofs;
    logic [LEN_W-1:0]  bases_left;
    logic              bases_kept;
    logic [QUAL_W-1:0] read_mq;
    int unsigned       list_len [WINDOW];
    logic [ENT_W-1:0]  list_mem [WINDOW*DEPTH];

    t_out_beat         awaited_results [$];
    int                mismatches = 0;
    int                n_awaited  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = n_awaited;

    function automatic string beat_str(t_out_beat b);
        return $sformatf("kind=%0d status=%0d nt=%0d q=%0d last=%0d",
                         b.kind, b.status, b.nucleotide, b.entry_quality, b.last);
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endfunction

    function automatic void await_beat(logic kind, t_status st, logic [NT_W-1:0] nt,
                                       logic [QUAL_W-1:0] q, logic last);
        t_out_beat b;
        b.kind          = kind;
        b.status        = st;
        b.nucleotide    = nt;
        b.entry_quality = q;
        b.last          = last;
        awaited_results.push_back(b);
    endfunction

    // saturating offset add
    function automatic logic [OFS_W-1:0] ofs_add(logic [OFS_W-1:0] a, logic [OFS_W-1:0] b);
        logic [OFS_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[OFS_W] ? '1 : sum[OFS_W-1:0];
    endfunction

    task automatic predict_item();
        t_status           st;
        int unsigned       pos;
        int unsigned       n;
        logic [NT_W-1:0]   nt;
        logic [QUAL_W-1:0] q;
        logic [ENT_W-1:0]  e;
        st = ST_OK;
        n  = 0;
        case (i_in.func)
            FN_START: begin
                read_mq    = i_in.map_quality;
                ref_ofs    = '0;
                bases_left = '0;
                bases_kept = 1'b0;
            end
            FN_OP: begin
                case (i_in.cigar_op)
                    OP_M: begin
                        bases_left = i_in.op_length;
                        bases_kept = 1'b1;
                    end
                    OP_I, OP_S: begin
                        bases_left = i_in.op_length;
                        bases_kept = 1'b0;
                    end
                    OP_D, OP_N: begin
                        ref_ofs    = ofs_add(ref_ofs, OFS_W'(i_in.op_length));
                        bases_left = '0;
                    end
                    default: st = ST_BAD_OP;
                endcase
            end
            FN_BASE: begin
                if (bases_left == '0) begin
                    st = ST_UNEXP;
                end else begin
                    bases_left--;
                    if (!bases_kept || i_in.base_code == BASE_N) begin
                        st = ST_SKIP;
                    end else if (ref_ofs >= OFS_W'(WINDOW)) begin
                        st = ST_OUT_WIN;
                    end else begin
                        pos = (head_pos + ref_ofs) % WINDOW;
                        if (list_len[pos] >= DEPTH) begin
                            st = ST_FULL;
                        end else begin
                            case (i_in.base_code)
                                BASE_A:  nt = 3'd1;
                                BASE_C:  nt = 3'd2;
                                BASE_G:  nt = 3'd3;
                                BASE_T:  nt = 3'd4;
                                default: nt = 3'd0;
                            endcase
                            q = (i_in.base_quality < read_mq) ? i_in.base_quality : read_mq;
                            list_mem[pos*DEPTH + list_len[pos]] = {nt, q};
                            list_len[pos]++;
                        end
                    end
                    if (bases_kept) ref_ofs = ofs_add(ref_ofs, 1);
                end
            end
            FN_MOVE: begin
                pos = head_pos;
                n   = list_len[pos];
                list_len[pos] = 0;
                head_pos = WIN_W'((pos + 1) % WINDOW);
                if (ref_ofs != '0) ref_ofs--;
                for (int k = 0; k < n; k++) begin
                    e = list_mem[pos*DEPTH + k];
                    await_beat(KIND_ENTRY, ST_OK, e[ENT_W-1:QUAL_W], e[QUAL_W-1:0],
                               k + 1 == n);
                end
            end
        endcase
        // everything but a non-empty move acknowledges once
        if (n == 0) await_beat(KIND_ACK, st, '0, '0, 1'b1);
    endtask

    task automatic check_result();
        t_out_beat got;
        t_out_beat want;
        string     bad;
        got.kind          = i_out.kind;
        got.status        = t_status'(i_out.status);
        got.nucleotide    = i_out.nucleotide;
        got.entry_quality = i_out.entry_quality;
        got.last          = i_out.last;
        if (awaited_results.size() == 0) begin
            flag_mismatch({"beat with nothing pending: ", beat_str(got)});
        end else begin
            want = awaited_results.pop_front();
            bad  = "";
            if (got.kind !== want.kind)                   bad = {bad, " kind"};
            if (got.status !== want.status)               bad = {bad, " status"};
            if (got.nucleotide !== want.nucleotide)       bad = {bad, " nucleotide"};
            if (got.entry_quality !== want.entry_quality) bad = {bad, " entry_quality"};
            if (got.last !== want.last)                   bad = {bad, " last"};
            if (bad != "") begin
                flag_mismatch($sformatf("field(s)%s: expected %s, got %s",
                                        bad, beat_str(want), beat_str(got)));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_pos   = '0;
            ref_ofs    = '0;
            bases_left = '0;
            bases_kept = 1'b0;
            read_mq    = '0;
            for (int p = 0; p < WINDOW; p++) list_len[p] = 0;
            awaited_results.delete();
        end else begin
            // results never leave in the cycle their item is taken
            if (i_out.valid && i_out.ready) check_result();
            if (i_in.valid && i_in.ready) predict_item();
        end
        n_awaited = awaited_results.size();
    end

endmodule

@@ tb/sv/cigar_pileup_window_tb.sv @@
//------------------------------------------------------------------------------
// cigar_pileup_window_tb
// Drives read starts, CIGAR ops, read bases and window moves into the pileup
// window with random gaps and output stalls; a checker alongside predicts and
// compares every result beat, and this top gives the verdict.
//------------------------------------------------------------------------------
module cigar_pileup_window_tb;
    import cpw_pkg::*;

    // quiet cycles (no beat on either channel) before giving up; covers the
    // clearing pass after reset plus the longest gap or stall with plenty to spare
    localparam int WATCHDOG_LIMIT = 5000;
    // quiet cycles after the last awaited beat, to catch strays (64-entry drain)
    localparam int TAIL_CYCLES    = 80;
    localparam int RANDOM_SPAN    = 30;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [QUAL_W-1:0] mapq;
        logic [OP_W-1:0]   op;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic [QUAL_W-1:0] bq;
    } t_item;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_beats;
    int   items_sent = 0;
    int   in_calm    = 0;   // remaining gap-free beats on the input side
    int   out_calm   = 0;   // same for the result side

    cpw_in_if  in_ch ();
    cpw_out_if out_ch ();

    cigar_pileup_window u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    cpw_pileup_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long; occasionally a
    // run of gap-free beats so back-to-back traffic is seen too.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Fields an item's function ignores are left random, so every bit moves.
    function automatic t_item rand_item();
        t_item it;
        it.func = FUNC_W'($urandom);
        it.mapq = QUAL_W'($urandom);
        it.op   = OP_W'($urandom);
        it.len  = LEN_W'($urandom);
        it.code = CODE_W'($urandom);
        it.bq   = QUAL_W'($urandom);
        return it;
    endfunction

    function automatic t_item start_item(logic [QUAL_W-1:0] mq);
        t_item it;
        it      = rand_item();
        it.func = FN_START;
        it.mapq = mq;
        return it;
    endfunction

    function automatic t_item op_item(logic [OP_W-1:0] op, logic [LEN_W-1:0] len);
        t_item it;
        it      = rand_item();
        it.func = FN_OP;
        it.op   = op;
        it.len  = len;
        return it;
    endfunction

    function automatic t_item base_item(logic [CODE_W-1:0] code, logic [QUAL_W-1:0] bq);
        t_item it;
        it      = rand_item();
        it.func = FN_BASE;
        it.code = code;
        it.bq   = bq;
        return it;
    endfunction

    function automatic t_item move_item();
        t_item it;
        it      = rand_item();
        it.func = FN_MOVE;
        return it;
    endfunction

    // mostly real nucleotides, some N, some arbitrary nibbles
    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] acgt [4] = '{BASE_A, BASE_C, BASE_G, BASE_T};
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return BASE_N;
        if (r == 1) return CODE_W'($urandom);
        return acgt[$urandom_range(0, 3)];
    endfunction

    // One beat on the item channel. Valid only drops when a gap is wanted,
    // so back-to-back beats keep it high with a single assignment per edge.
    task automatic send(input t_item it);
        int gap;
        gap = pick_gap(in_calm);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.func         = it.func;
        in_ch.map_quality  = it.mapq;
        in_ch.cigar_op     = it.op;
        in_ch.op_length    = it.len;
        in_ch.base_code    = it.code;
        in_ch.base_quality = it.bq;
        in_ch.valid        = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // A read with random content: start, a few ops, now and then a bad op code,
    // the bases they call for, sometimes one base too many or too few, now and
    // then a stray move in the middle, then a few moves of the head.
    task automatic run_read();
        int               n_ops;
        int               n_bases;
        int               r;
        logic [OP_W-1:0]  op;
        logic [LEN_W-1:0] len;
        send(start_item(QUAL_W'($urandom)));
        n_ops = $urandom_range(1, 5);
        repeat (n_ops) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                op  = OP_M;
                len = LEN_W'($urandom_range(0, 8));
            end else if (r < 78) begin
                op  = (r < 68) ? OP_I : OP_S;
                len = LEN_W'($urandom_range(0, 4));
            end else if (r < 94) begin
                op  = (r < 86) ? OP_D : OP_N;
                // now and then jump past the window end
                len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(900, 1100))
                                                  : LEN_W'($urandom_range(0, 6));
            end else begin
                op  = OP_W'($urandom_range(5, 15));
                len = LEN_W'($urandom);
            end
            send(op_item(op, len));
            if (op == OP_M || op == OP_I || op == OP_S) begin
                n_bases = int'(len);
                r = $urandom_range(0, 19);
                if (r == 0) n_bases++;
                else if (r == 1 && n_bases > 0) n_bases--;
                repeat (n_bases) begin
                    send(base_item(pick_code(), QUAL_W'($urandom)));
                    if ($urandom_range(0, 29) == 0) send(move_item());
                end
            end
        end
        repeat ($urandom_range(0, 3)) send(move_item());
    endtask

    task automatic run_random(input int span);
        int stop_at;
        stop_at = items_sent + span;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 85) begin
                run_read();
            end else begin
                // noise: any function, any field values
                repeat ($urandom_range(1, 4)) send(rand_item());
            end
        end
    endtask

    // Result side: ready high for a while, then a random stall.
    initial begin
        int high_len;
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            high_len = $urandom_range(1, 16);
            @(negedge i_clk);
            out_ch.ready = 1'b1;
            repeat (high_len - 1) @(negedge i_clk);
            gap = pick_gap(out_calm);
            if (gap > 0) begin
                @(negedge i_clk);
                out_ch.ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.func         = FN_START;
        in_ch.map_quality  = '0;
        in_ch.cigar_op     = OP_M;
        in_ch.op_length    = '0;
        in_ch.base_code    = '0;
        in_ch.base_quality = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part ----
        // highest mapping quality; min() picks the base quality either way
        send(start_item(8'd255));
        send(op_item(OP_M, 28'd3));
        send(base_item(BASE_A, 8'd0));          // offset 0
        send(base_item(BASE_C, 8'd255));        // offset 1
        send(base_item(BASE_N, 8'd30));         // N base: dropped, offset still moves
        send(base_item(BASE_T, 8'd40));         // no bases pending: unexpected
        send(op_item(OP_W'(15), '1));           // bad op, state untouched
        send(op_item(OP_I, 28'd1));
        send(base_item(BASE_G, 8'd77));         // insertion base skipped
        send(op_item(OP_S, 28'd1));
        send(base_item(BASE_T, 8'd12));         // soft clip skipped
        send(op_item(OP_D, 28'd2));             // offset 3 -> 5
        send(op_item(OP_N, 28'd1));             // offset 6
        send(op_item(OP_M, 28'd2));
        send(base_item(BASE_G, 8'd100));        // stored at offset 6
        // new read with one base still pending: pending op is cleared
        send(start_item(8'd0));
        send(base_item(BASE_A, 8'd50));         // unexpected
        send(op_item(OP_M, 28'd1));
        send(base_item(BASE_T, 8'd255));        // quality capped by mapq 0
        send(op_item(OP_D, '1));                // longest deletion
        send(op_item(OP_M, 28'd1));
        send(base_item(BASE_A, 8'd9));          // past the window end
        send(move_item());                      // head list of two entries
        send(move_item());                      // one entry
        send(move_item());                      // empty list: plain ack

        // ---- random part ----
        run_random(RANDOM_SPAN);

        // one position filled to DEPTH and beyond, then drained in one go
        repeat (DEPTH + 2) begin
            send(start_item(QUAL_W'($urandom_range(128, 255))));
            send(op_item(OP_M, LEN_W'($urandom_range(1, 3))));
            send(base_item(pick_code() == BASE_N ? BASE_A : BASE_G, QUAL_W'($urandom)));
        end
        send(move_item());

        // offset saturation: seventeen longest deletions overrun 32 bits
        send(start_item(QUAL_W'($urandom)));
        repeat (17) send(op_item(OP_D, '1));
        send(op_item(OP_M, 28'd2));
        send(base_item(BASE_C, 8'd20));
        send(base_item(BASE_T, 8'd21));
        send(move_item());                      // offset one below the top
        send(op_item(OP_N, 28'd5));             // back to the top
        send(op_item(OP_M, 28'd1));
        send(base_item(BASE_G, 8'd22));
        send(move_item());

        run_random(RANDOM_SPAN);

        @(negedge i_clk);
        in_ch.valid = 1'b0;

        // drain everything still due, then watch a little longer for strays
        wait (pending_beats == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending_beats == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/cpw_pkg.sv
sv/cpw_if.sv
sv/cpw_ram.sv
sv/cpw_out_buf.sv
sv/cigar_pileup_window.sv
tb/sv/cpw_pileup_checker.sv
tb/sv/cigar_pileup_window_tb.sv
